// ===== rtl/core/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants for the bipartite graph check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

    // Width of one vertex endpoint and of the vertex count register
    localparam int VERTEX_W = 11;

    // Vertex count after reset
    localparam logic [VERTEX_W-1:0] NUM_VERTICES_RESET = 11'd1024;

    // Width of the epoch tag kept with every store entry
    localparam int EPOCH_W = 4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_A,
        S_WALK_B,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic is_bipartite;
        logic range_error;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bgc_edge_if.sv =====
// ----------------------------------------------------------------------------
// bgc_edge_if
// Valid/ready channel that carries one graph edge per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgc_edge_if;
    logic                         valid;
    logic                         ready;
    logic [bgc_pkg::VERTEX_W-1:0] first_vertex;
    logic [bgc_pkg::VERTEX_W-1:0] second_vertex;
    logic                         last_edge;

    modport source (
        output valid,
        output first_vertex,
        output second_vertex,
        output last_edge,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_vertex,
        input  second_vertex,
        input  last_edge,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/bgc_result_if.sv =====
// ----------------------------------------------------------------------------
// bgc_result_if
// Valid/ready channel that carries one check result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgc_result_if;
    logic valid;
    logic ready;
    logic is_bipartite;
    logic range_error;

    modport source (
        output valid,
        output is_bipartite,
        output range_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  is_bipartite,
        input  range_error,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/bgc_store.sv =====
// ----------------------------------------------------------------------------
// bgc_store
// Union-find store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 15
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgc_ctrl
// Sequencer: range check, root walks through the store, union and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_ctrl #(
    parameter int MAX_VERTICES = 1024,
    parameter int VW           = 10,
    parameter int DW           = 15
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    bgc_edge_if.sink                          edge_ch,
    input  wire logic [bgc_pkg::VERTEX_W-1:0] num_vertices,
    input  wire logic                         out_free,
    output logic                              res_load,
    output bgc_pkg::result_t                  result,
    output logic                              wr_en,
    output logic      [VW-1:0]                wr_addr,
    output logic      [DW-1:0]                wr_data,
    output logic                              rd_en,
    output logic      [VW-1:0]                rd_addr,
    input  wire logic [DW-1:0]                rd_data
);

    localparam int FW = bgc_pkg::VERTEX_W;
    localparam int EW = bgc_pkg::EPOCH_W;
    localparam int LW = ($clog2(MAX_VERTICES + 1) > FW) ? $clog2(MAX_VERTICES + 1) : FW;
    localparam logic [VW-1:0] LAST_ADDR = VW'(MAX_VERTICES - 1);
    localparam logic [EW-1:0] EPOCH_TOP = {EW{1'b1}};

    bgc_pkg::state_t state_reg, state_next;
    logic [VW-1:0]   cur_reg, cur_next;
    logic            par_reg, par_next;
    logic [VW-1:0]   ra_reg, ra_next;
    logic            pa_reg, pa_next;
    logic [FW-1:0]   b_reg, b_next;
    logic            last_reg, last_next;
    logic            odd_reg, odd_next;
    logic            rerr_reg, rerr_next;
    logic [EW-1:0]   epoch_reg, epoch_next;
    logic [VW-1:0]   clr_reg, clr_next;

    logic [LW-1:0]   limit;
    logic            a_bad, b_bad;
    logic [VW-1:0]   a_idx, b_idx;
    logic            tag_hit;
    logic [VW-1:0]   up;
    logic            up_par;

    // Effective count: register capped at store depth
    assign limit = (LW'(num_vertices) > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES)
                                                           : LW'(num_vertices);
    assign a_bad = (edge_ch.first_vertex == '0) || (LW'(edge_ch.first_vertex) > limit);
    assign b_bad = (edge_ch.second_vertex == '0) || (LW'(edge_ch.second_vertex) > limit);
    assign a_idx = VW'(edge_ch.first_vertex - FW'(1));
    assign b_idx = VW'(b_reg - FW'(1));

    // Entry layout {epoch, parent, parity}; a stale epoch reads as a root
    assign tag_hit = (rd_data[DW-1 -: EW] == epoch_reg);
    assign up      = tag_hit ? rd_data[VW:1] : cur_reg;
    assign up_par  = tag_hit & rd_data[0];

    assign result.is_bipartite = !odd_reg && !rerr_reg;
    assign result.range_error  = rerr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bgc_pkg::S_CLEAR;
            clr_reg   <= '0;
            epoch_reg <= '0;
            odd_reg   <= 1'b0;
            rerr_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            epoch_reg <= epoch_next;
            odd_reg   <= odd_next;
            rerr_reg  <= rerr_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        par_reg <= par_next;
        ra_reg  <= ra_next;
        pa_reg  <= pa_next;
        b_reg   <= b_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        par_next      = par_reg;
        ra_next       = ra_reg;
        pa_next       = pa_reg;
        b_next        = b_reg;
        last_next     = last_reg;
        odd_next      = odd_reg;
        rerr_next     = rerr_reg;
        epoch_next    = epoch_reg;
        clr_next      = clr_reg;
        rd_en         = 1'b0;
        rd_addr       = cur_reg;
        wr_en         = 1'b0;
        wr_addr       = clr_reg;
        wr_data       = {{EW{1'b0}}, clr_reg, 1'b0};
        res_load      = 1'b0;
        edge_ch.ready = 1'b0;

        case (state_reg)
            bgc_pkg::S_CLEAR:
            begin
                // Write identity entries, one per cycle
                wr_en = 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = bgc_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + VW'(1);
                end
            end

            bgc_pkg::S_IDLE:
            begin
                edge_ch.ready = 1'b1;
                if (edge_ch.valid)
                begin
                    b_next    = edge_ch.second_vertex;
                    last_next = edge_ch.last_edge;
                    if (a_bad || b_bad)
                    begin
                        rerr_next  = 1'b1;
                        state_next = bgc_pkg::S_FINISH;
                    end
                    else if (edge_ch.first_vertex == edge_ch.second_vertex)
                    begin
                        odd_next   = 1'b1;
                        state_next = bgc_pkg::S_FINISH;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = a_idx;
                        cur_next   = a_idx;
                        par_next   = 1'b0;
                        state_next = bgc_pkg::S_WALK_A;
                    end
                end
            end

            bgc_pkg::S_WALK_A:
            begin
                if (up == cur_reg)
                begin
                    ra_next    = cur_reg;
                    pa_next    = par_reg;
                    rd_en      = 1'b1;
                    rd_addr    = b_idx;
                    cur_next   = b_idx;
                    par_next   = 1'b0;
                    state_next = bgc_pkg::S_WALK_B;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = up;
                    cur_next = up;
                    par_next = par_reg ^ up_par;
                end
            end

            bgc_pkg::S_WALK_B:
            begin
                if (up == cur_reg)
                begin
                    if (cur_reg == ra_reg)
                    begin
                        if (par_reg == pa_reg)
                        begin
                            odd_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // Hang root A under root B, endpoints on opposite sides
                        wr_en   = 1'b1;
                        wr_addr = ra_reg;
                        wr_data = {epoch_reg, cur_reg, pa_reg ^ par_reg ^ 1'b1};
                    end
                    state_next = bgc_pkg::S_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = up;
                    cur_next = up;
                    par_next = par_reg ^ up_par;
                end
            end

            bgc_pkg::S_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = bgc_pkg::S_IDLE;
                end
                else if (out_free)
                begin
                    // Deliver, drop the flags and retire the store by epoch
                    res_load   = 1'b1;
                    odd_next   = 1'b0;
                    rerr_next  = 1'b0;
                    epoch_next = epoch_reg + EW'(1);
                    if (epoch_reg == EPOCH_TOP)
                    begin
                        state_next = bgc_pkg::S_CLEAR;
                    end
                    else
                    begin
                        state_next = bgc_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = bgc_pkg::S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/bipartite_graph_check_unit.sv =====
// ----------------------------------------------------------------------------
// bipartite_graph_check_unit
// Two-coloring check of an undirected graph streamed in edge by edge.
// ----------------------------------------------------------------------------
// Usage:
//   edge_ch takes one edge per item (1-based endpoints, last_edge marks the
//   end of a graph). result_ch gives one item per graph, on its last edge:
//   is_bipartite and range_error. cfg_wr_en/cfg_wr_data load the vertex
//   count; endpoints of 0 or above min(count, MAX_VERTICES) are range errors.
// Timing:
//   An edge in range holds ready low from acceptance while its endpoints
//   walk their parent chains to the roots and then pass a finish state;
//   the single read port of the union-find store sets this, one parent per
//   cycle. A self-loop or out-of-range edge goes straight to the finish state.
//   The last edge's finish state loads the result into the output register.
// Reset and clearing:
//   After reset, and after every 16th result, the store is swept once, each
//   entry set to identity one per cycle, with edge_ch.ready low. Between sweeps an epoch tag
//   on each entry retires the previous graph's entries at no cost.
// Stalls:
//   The result waits in an output register; while it is held the block
//   still takes the next graph's edges, and only a second result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bipartite_graph_check_unit #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    bgc_edge_if.sink                          edge_ch,
    bgc_result_if.source                      result_ch,
    input  wire logic                         cfg_wr_en,
    input  wire logic [bgc_pkg::VERTEX_W-1:0] cfg_wr_data
);

    // Store geometry: parent index, parity, epoch tag
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int DW = bgc_pkg::EPOCH_W + VW + 1;

    logic [bgc_pkg::VERTEX_W-1:0] num_vertices_reg;
    logic                         out_valid_reg;
    bgc_pkg::result_t             out_data_reg;

    logic                         out_free;
    logic                         res_load;
    bgc_pkg::result_t             result;
    logic                         wr_en;
    logic [VW-1:0]                wr_addr;
    logic [DW-1:0]                wr_data;
    logic                         rd_en;
    logic [VW-1:0]                rd_addr;
    logic [DW-1:0]                rd_data;

    // Vertex count register; to be written only while idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= bgc_pkg::NUM_VERTICES_RESET;
        end
        else if (cfg_wr_en)
        begin
            num_vertices_reg <= cfg_wr_data;
        end
    end

    // Output register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= result;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.is_bipartite = out_data_reg.is_bipartite;
    assign result_ch.range_error  = out_data_reg.range_error;

    bgc_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW),
        .DW           (DW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_ch      (edge_ch),
        .num_vertices (num_vertices_reg),
        .out_free     (out_free),
        .res_load     (res_load),
        .result       (result),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    bgc_store #(
        .DEPTH   (MAX_VERTICES),
        .AW      (VW),
        .DW      (DW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bgc_check.sv =====
// ----------------------------------------------------------------------------
// bgc_check
// Port-level checks for the bipartite graph check unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_check (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic is_bipartite,
    input wire logic range_error
);

    // A range error never comes with a bipartite verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(range_error && is_bipartite))
        else $error("range error reported with is_bipartite set");

    // After an accepted edge, ready is low in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("edge accepted on back-to-back cycles");

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(is_bipartite) && $stable(range_error)))
        else $error("result payload changed while stalled");

endmodule

bind bipartite_graph_check_unit bgc_check u_bgc_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (edge_ch.valid),
    .in_ready     (edge_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .is_bipartite (result_ch.is_bipartite),
    .range_error  (result_ch.range_error)
);

`default_nettype wire
